### rtl/core/cpa_pkg.sv
`timescale 1ns / 1ps
package cpa_pkg;
   localparam int ChunkCount = 256;
   localparam int IdxW = $clog2(ChunkCount);
   localparam int CntW = $clog2(ChunkCount + 1);
   localparam int ByteW = 20;
   localparam int SizeW = 13;
   localparam int StatW = 3;

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;

   localparam logic [StatW-1:0] ST_OK = 3'd0;
   localparam logic [StatW-1:0] ST_NOSPACE = 3'd1;
   localparam logic [StatW-1:0] ST_ZERO = 3'd2;
   localparam logic [StatW-1:0] ST_RANGE = 3'd3;
   localparam logic [StatW-1:0] ST_NOHEAD = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

### rtl/core/cpa_div.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle.
module cpa_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [cpa_pkg::ByteW:0]  dividend,
   input  logic [cpa_pkg::SizeW-1:0] divisor,
   output cpa_pkg::div_ctl_type     ctl,
   output logic [cpa_pkg::ByteW:0]  quotient
);
   import cpa_pkg::*;
   localparam int NW = ByteW + 1;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [SizeW:0] rem_ff, rem_in;
   logic [SizeW-1:0] dv_ff, dv_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [SizeW+1:0] trial;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; dv_in = dv_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, q_ff[NW-1]} - {2'b00, dv_ff};
      if (start) begin
         q_in = dividend; rem_in = '0; dv_in = divisor;
         cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[SizeW+1]) begin
            rem_in = trial[SizeW:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SizeW-1:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; dv_ff <= dv_in;
   end

   assign ctl = '{start: start, busy: busy_ff, done: done_ff};
   assign quotient = q_ff;
endmodule

### rtl/core/chunk_pool_allocator.sv
`timescale 1ns / 1ps
// First-fit chunk pool allocator over 256 chunks of csr chunk_size bytes.
// Request channel: pulse req_start with req_cmd (0 allocate, 1 free) and
// the byte count or byte offset while rsp_busy is low; the request is taken
// at that edge and rsp_busy stays high until the response is issued.
// Response channel: rsp_valid marks rsp_status, rsp_alloc_offset and
// rsp_free_chunks for exactly one cycle; the receiver cannot stall it.
// Sequence: the request is taken and divided (one quotient bit per cycle in
// the shared divider), then at most one memory access per cycle while the
// marker list is scanned: a marker read, a run read and a check per marker
// for an allocate, a marker read and a compare per marker in each of up to
// two passes of a free, then the update states. A zero-size allocate skips
// the scan and goes straight from the divide to the response.
// The marker scans dominate the response time.
// Only one request is in flight; the next is taken in the response cycle.
// Config: csr_valid/csr_ready write chunk_size (0 acts as 1); the user is to
// write only while idle, the block does not enforce it. Reset: a sweep of all
// 256 entries clears the chunk state after reset, during which rsp_busy is
// high; csr writes are taken throughout.
module chunk_pool_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cpa_pkg::SizeW-1:0] csr_chunk_size,
   input  logic                      req_start,
   output logic                      rsp_busy,
   input  logic                      req_cmd,
   input  logic [cpa_pkg::ByteW-1:0] req_alloc_bytes,
   input  logic [cpa_pkg::ByteW-1:0] req_free_offset,
   output logic                      rsp_valid,
   output logic [cpa_pkg::StatW-1:0] rsp_status,
   output logic [cpa_pkg::ByteW-1:0] rsp_alloc_offset,
   output logic [cpa_pkg::CntW-1:0]  rsp_free_chunks
);
   import cpa_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DIV, S_DIVW, S_A_SCAN, S_A_RD, S_A_CHK, S_A_NXT,
      S_A_UPD, S_F_RD, S_F_CHK, S_F_LAST, S_F_NXT, S_F_FIND, S_F_FRD,
      S_F_MERGE, S_F_PREV, S_F_PRD, S_F_BACK, S_F_ADD, S_DONE
   } state_type;

   // memories: read data registered
   logic      used_mem [ChunkCount];
   cnt_type   run_mem  [ChunkCount];
   cnt_type   frl_mem  [ChunkCount];
   idx_type   mk_mem   [ChunkCount];

   state_type state_ff;
   logic [SizeW-1:0] csize_ff;
   logic [SizeW-1:0] cs_eff;
   logic cmd_ff;
   logic [ByteW-1:0] arg_ff;
   cnt_type mcnt_ff, total_ff, need_ff, n_ff, merged_ff, dist_ff;
   cnt_type i_ff;
   cnt_type slot_ff, best_ff;
   idx_type head_ff, first_ff, last_ff, clr_ff;
   logic last_end_ff, starts_ff, found_ff;
   logic [StatW-1:0] st_ff;
   logic [ByteW-1:0] off_ff;
   logic [ByteW+SizeW-1:0] prod;

   // memory ports (driven in sequencer)
   logic used_rd_ff, used_rd2_ff;
   cnt_type run_rd_ff, frl_rd_ff;
   idx_type mk_rd_ff;
   logic [1:0] phase_ff;

   // divider
   logic div_go;
   logic [ByteW:0] div_num, div_q;
   div_ctl_type div_ctl;

   assign cs_eff = (csize_ff == '0) ? SizeW'(1) : csize_ff;
   assign div_go = (state_ff == S_DIV);
   assign div_num = (cmd_ff == CMD_ALLOC) ?
                    ({1'b0, arg_ff} + (ByteW+1)'(cs_eff) - 1'b1) : {1'b0, arg_ff};
   assign prod = ByteW'(head_ff) * cs_eff;

   cpa_div u_div (
      .clock(clock), .reset(reset), .start(div_go), .dividend(div_num),
      .divisor(cs_eff), .ctl(div_ctl), .quotient(div_q)
   );

   assign csr_ready = 1'b1;
   assign rsp_busy = (state_ff != S_IDLE);

   idx_type m_idx;
   assign m_idx = mk_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; csize_ff <= SizeW'(64);
         mcnt_ff <= CntW'(1); total_ff <= CntW'(ChunkCount);
         rsp_valid <= 1'b0;
      end else begin
         // strobe the response in the cycle that follows the done state
         rsp_valid <= (state_ff == S_DONE);
         if (csr_valid) csize_ff <= csr_chunk_size;
         unique case (state_ff)
            S_CLEAR: begin
               // sweep: entry 0 takes the whole-pool run
               used_mem[clr_ff] <= 1'b0;
               run_mem[clr_ff] <= '0;
               frl_mem[clr_ff] <= (clr_ff == '0) ? CntW'(ChunkCount) : '0;
               mk_mem[clr_ff] <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == idx_type'(ChunkCount - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_start) begin
               cmd_ff <= req_cmd;
               arg_ff <= (req_cmd == CMD_ALLOC) ? req_alloc_bytes : req_free_offset;
               state_ff <= S_DIV;
            end
            S_DIV: state_ff <= S_DIVW;
            S_DIVW: if (div_ctl.done) begin
               if (cmd_ff == CMD_ALLOC) begin
                  if (div_q == '0) begin
                     st_ff <= ST_ZERO; state_ff <= S_DONE;
                  end else if (div_q > (ByteW+1)'(ChunkCount)) begin
                     st_ff <= ST_NOSPACE; state_ff <= S_DONE;
                  end else begin
                     need_ff <= CntW'(div_q); i_ff <= mcnt_ff;
                     state_ff <= S_A_SCAN;
                  end
               end else begin
                  if (div_q >= (ByteW+1)'(ChunkCount)) begin
                     st_ff <= ST_RANGE; state_ff <= S_DONE;
                  end else begin
                     first_ff <= IdxW'(div_q);
                     used_rd_ff <= used_mem[IdxW'(div_q)];
                     run_rd_ff <= run_mem[IdxW'(div_q)];
                     state_ff <= S_F_CHK;
                  end
               end
            end
            // allocate: newest to oldest marker
            S_A_SCAN: begin
               if (i_ff == '0) begin
                  st_ff <= ST_NOSPACE; state_ff <= S_DONE;
               end else begin
                  mk_rd_ff <= mk_mem[IdxW'(i_ff - 1'b1)];
                  state_ff <= S_A_RD;
               end
            end
            S_A_RD: begin
               frl_rd_ff <= frl_mem[m_idx];
               state_ff <= S_A_CHK;
            end
            S_A_CHK: begin
               if (frl_rd_ff >= need_ff) begin
                  slot_ff <= i_ff - 1'b1;
                  head_ff <= m_idx;
                  // last chunk, clamped to the pool end
                  if ({1'b0, m_idx} + need_ff - 1'b1 >= CntW'(ChunkCount)) begin
                     last_ff <= idx_type'(ChunkCount - 1); last_end_ff <= 1'b1;
                  end else begin
                     last_ff <= IdxW'({1'b0, m_idx} + need_ff - 1'b1);
                     last_end_ff <= (IdxW'({1'b0, m_idx} + need_ff - 1'b1)
                                     == idx_type'(ChunkCount - 1));
                  end
                  phase_ff <= '0;
                  state_ff <= S_A_UPD;
               end else begin
                  i_ff <= i_ff - 1'b1; state_ff <= S_A_SCAN;
               end
            end
            S_A_UPD: begin
               unique case (phase_ff)
                  2'd0: begin
                     run_mem[head_ff] <= need_ff;
                     used_mem[head_ff] <= 1'b1;
                     if (!last_end_ff) used_rd2_ff <= used_mem[last_ff + 1'b1];
                     phase_ff <= 2'd1;
                  end
                  2'd1: begin
                     used_mem[last_ff] <= 1'b1;
                     if (!last_end_ff && !(used_rd2_ff || (last_ff + 1'b1 == head_ff))) begin
                        mk_mem[IdxW'(slot_ff)] <= last_ff + 1'b1;
                        frl_mem[last_ff + 1'b1] <= frl_rd_ff - need_ff;
                        phase_ff <= 2'd3;
                     end else begin
                        mk_rd_ff <= mk_mem[IdxW'(mcnt_ff - 1'b1)];
                        phase_ff <= 2'd2;
                     end
                  end
                  2'd2: begin
                     mk_mem[IdxW'(slot_ff)] <= mk_rd_ff;
                     phase_ff <= 2'd3;
                     mcnt_ff <= mcnt_ff - 1'b1;
                  end
                  default: begin
                     // the moved marker may land on head only if need is 0
                     frl_mem[head_ff] <= '0;
                     total_ff <= total_ff - need_ff;
                     off_ff <= prod[ByteW-1:0];
                     st_ff <= ST_OK; state_ff <= S_DONE;
                  end
               endcase
            end
            // free
            S_F_CHK: begin
               if (!used_rd_ff || run_rd_ff == '0) begin
                  st_ff <= ST_NOHEAD; state_ff <= S_DONE;
               end else begin
                  n_ff <= run_rd_ff;
                  if ({1'b0, first_ff} + run_rd_ff - 1'b1 >= CntW'(ChunkCount)) begin
                     last_ff <= idx_type'(ChunkCount - 1); last_end_ff <= 1'b1;
                  end else begin
                     last_ff <= IdxW'({1'b0, first_ff} + run_rd_ff - 1'b1);
                     last_end_ff <= (IdxW'({1'b0, first_ff} + run_rd_ff - 1'b1)
                                     == idx_type'(ChunkCount - 1));
                  end
                  used_mem[first_ff] <= 1'b0;
                  run_mem[first_ff] <= '0;
                  state_ff <= S_F_LAST;
               end
            end
            S_F_LAST: begin
               used_mem[last_ff] <= 1'b0;
               if (first_ff != '0) used_rd_ff <= used_mem[first_ff - 1'b1];
               if (!last_end_ff) frl_rd_ff <= frl_mem[last_ff + 1'b1];
               state_ff <= S_F_NXT;
            end
            S_F_NXT: begin
               starts_ff <= (first_ff == '0) ||
                            (used_rd_ff && !((first_ff - 1'b1) == last_ff));
               i_ff <= '0; found_ff <= 1'b0;
               total_ff <= total_ff + n_ff;
               if (!last_end_ff && frl_rd_ff != '0) state_ff <= S_F_FIND;
               else state_ff <= S_F_MERGE;
            end
            S_F_FIND: begin
               if (i_ff == mcnt_ff) state_ff <= S_F_MERGE;
               else begin
                  mk_rd_ff <= mk_mem[IdxW'(i_ff)];
                  state_ff <= S_F_FRD;
               end
            end
            S_F_FRD: begin
               if (m_idx == last_ff + 1'b1) begin
                  found_ff <= 1'b1; slot_ff <= i_ff; state_ff <= S_F_MERGE;
               end else begin
                  i_ff <= i_ff + 1'b1; state_ff <= S_F_FIND;
               end
            end
            S_F_MERGE: begin
               if (found_ff) begin
                  merged_ff <= frl_rd_ff + n_ff;
                  frl_mem[last_ff + 1'b1] <= '0;
                  if (starts_ff) begin
                     mk_mem[IdxW'(slot_ff)] <= first_ff;
                     phase_ff <= 2'd1;
                     state_ff <= S_F_ADD;
                  end else begin
                     mk_rd_ff <= mk_mem[IdxW'(mcnt_ff - 1'b1)];
                     phase_ff <= 2'd2;
                     state_ff <= S_F_ADD;
                  end
               end else begin
                  merged_ff <= n_ff;
                  if (starts_ff) begin
                     phase_ff <= 2'd0; state_ff <= S_F_ADD;
                  end else begin
                     i_ff <= mcnt_ff; best_ff <= mcnt_ff; dist_ff <= '1;
                     state_ff <= S_F_PREV;
                  end
               end
            end
            S_F_PREV: begin
               if (i_ff == '0) state_ff <= S_F_BACK;
               else begin
                  mk_rd_ff <= mk_mem[IdxW'(i_ff - 1'b1)];
                  state_ff <= S_F_PRD;
               end
            end
            S_F_PRD: begin
               if (first_ff > m_idx &&
                   CntW'(first_ff - m_idx) < dist_ff) begin
                  dist_ff <= CntW'(first_ff - m_idx);
                  best_ff <= i_ff - 1'b1;
                  head_ff <= m_idx;
               end
               i_ff <= i_ff - 1'b1;
               state_ff <= S_F_PREV;
            end
            S_F_BACK: begin
               if (best_ff < mcnt_ff) begin
                  frl_rd_ff <= frl_mem[head_ff];
                  phase_ff <= 2'd3; state_ff <= S_F_ADD;
               end else begin
                  phase_ff <= 2'd0; state_ff <= S_F_ADD;
               end
            end
            S_F_ADD: begin
               unique case (phase_ff)
                  2'd0: begin
                     // new marker for the released run, if the list has room
                     if (mcnt_ff < CntW'(ChunkCount)) begin
                        mk_mem[IdxW'(mcnt_ff)] <= first_ff;
                        frl_mem[first_ff] <= merged_ff;
                        mcnt_ff <= mcnt_ff + 1'b1;
                     end
                     st_ff <= ST_OK; state_ff <= S_DONE;
                  end
                  2'd1: begin
                     frl_mem[first_ff] <= merged_ff;
                     st_ff <= ST_OK; state_ff <= S_DONE;
                  end
                  2'd2: begin
                     // drop the found marker, then merge backward
                     mk_mem[IdxW'(slot_ff)] <= mk_rd_ff;
                     mcnt_ff <= mcnt_ff - 1'b1;
                     frl_mem[first_ff] <= '0;
                     i_ff <= mcnt_ff - 1'b1; best_ff <= mcnt_ff - 1'b1;
                     dist_ff <= '1; found_ff <= 1'b0;
                     state_ff <= S_F_PREV;
                  end
                  default: begin
                     frl_mem[head_ff] <= frl_rd_ff + merged_ff;
                     st_ff <= ST_OK; state_ff <= S_DONE;
                  end
               endcase
            end
            S_DONE: begin
               rsp_status <= st_ff;
               rsp_alloc_offset <= (st_ff == ST_OK && cmd_ff == CMD_ALLOC) ?
                                   off_ff : '0;
               rsp_free_chunks <= total_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### rtl/core/cpa_checker.sv
`timescale 1ns / 1ps
module cpa_checker (
   input logic clock,
   input logic reset,
   input logic req_start,
   input logic rsp_busy,
   input logic rsp_valid,
   input logic [cpa_pkg::StatW-1:0] rsp_status,
   input logic [cpa_pkg::ByteW-1:0] rsp_alloc_offset,
   input logic [cpa_pkg::CntW-1:0] rsp_free_chunks
);
   import cpa_pkg::*;
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_alloc_offset == '0)
      else $error("offset on error");
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_chunks <= CntW'(ChunkCount)) else $error("total");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_start && !rsp_busy |=> rsp_busy) else $error("not busy");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_NOHEAD) else $error("status code");
endmodule

bind chunk_pool_allocator cpa_checker u_cpa_checker (
   .clock(clock), .reset(reset), .req_start(req_start), .rsp_busy(rsp_busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_alloc_offset(rsp_alloc_offset), .rsp_free_chunks(rsp_free_chunks)
);
